[rtl/mstp_pkg.sv]
// mstp_pkg: shared constants and command codes of the minimum spanning tree unit
// no dependencies; imported by the top level and used for the RAM defaults
`default_nettype none

package mstp_pkg;

  // default sizing of the graph engine
  localparam int unsigned MAX_NODES   = 32;
  localparam int unsigned WEIGHT_BITS = 16;

  // command carried in the input tuser
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

endpackage

`default_nettype wire

[rtl/mstp_ram.sv]
// mstp_ram: generic simple dual-port RAM, one write and one registered read port
// depends on mstp_pkg for its default sizing only
`default_nettype none

module mstp_ram #(
  parameter int unsigned Width = mstp_pkg::WEIGHT_BITS + 1,
  parameter int unsigned Depth = mstp_pkg::MAX_NODES * mstp_pkg::MAX_NODES,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/minimum_spanning_tree_prim_unit.sv]
// minimum_spanning_tree_prim_unit: Prim spanning tree engine over a dense weight matrix
// depends on mstp_pkg and mstp_ram (matrix storage)
//
// Usage: edges, run and clear commands enter on the s_axis channel (command in tuser).
// The node count register is written on the cfg channel, which is always ready.
// An add-edge word compares the new weight with the stored one in S_ADD_CMP and writes
// both matrix halves (S_ADD_CMP, S_ADD_WR2) only when the stored weight changes; a self
// loop or an unused command is taken in S_IDLE alone. A clear word sweeps the whole
// matrix, one entry a cycle. The same sweep runs right after reset, and no word
// is taken until it is done.
// A run word grows the tree with one shared signed comparator: each tree step scans
// the n node keys and then relaxes one matrix row through the RAM read port; up to
// n steps are followed by a last scan that finds nothing, then n-1 result words
// leave on m_axis, one per cycle while the receiver is ready, the last with tlast
// and the tree total.
// The result register parts the two sides: while the receiver stalls the engine
// holds its word, and once the last word is loaded the next input word is taken.
`default_nettype none

module minimum_spanning_tree_prim_unit #(
  parameter int unsigned MaxNodes   = mstp_pkg::MAX_NODES,
  parameter int unsigned WeightBits = mstp_pkg::WEIGHT_BITS,
  localparam int unsigned NodeW = $clog2(MaxNodes),
  localparam int unsigned CntW  = $clog2(MaxNodes + 1),
  localparam int unsigned TotW  = WeightBits + NodeW,
  localparam int unsigned InW   = ((2 * NodeW + WeightBits + 7) / 8) * 8,
  localparam int unsigned OutW  = ((2 * NodeW + WeightBits + TotW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // node count register
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CntW-1:0] cfg_data_i,
  // command words
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // end_a, end_b, edge_weight
  input  logic [1:0]      s_axis_tuser,   // opcode
  // result words
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata,   // node_index, parent_index, node_key, total_weight
  output logic [0:0]      m_axis_tuser,   // reached
  output logic            m_axis_tlast
);

  import mstp_pkg::*;

  localparam int unsigned AddrW = 2 * NodeW;
  localparam int unsigned Depth = 1 << AddrW;
  localparam logic [CntW-1:0] MaxN = CntW'(MaxNodes);
  localparam logic [CntW-1:0] MinN = CntW'(2);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_ADD_CMP,
    S_ADD_WR2,
    S_SCAN,
    S_RELAX,
    S_DRAIN,
    S_EMIT
  } state_e;

  // control state
  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [AddrW-1:0]    clr_q, clr_d;
  logic [NodeW-1:0]    idx_q, idx_d;
  logic                bfound_q, bfound_d;
  logic                rv_q, rv_d;
  logic                ovalid_q, ovalid_d;
  logic [MaxNodes-1:0] fin_q, fin_d;
  logic [MaxNodes-1:0] vis_q, vis_d;

  // payload state
  logic [NodeW-1:0]      a_q, a_d, b_q, b_d;
  logic [WeightBits-1:0] w_q, w_d;
  logic [NodeW-1:0]      nlast_q, nlast_d;
  logic [NodeW-1:0]      best_q, best_d;
  logic [WeightBits-1:0] bkey_q, bkey_d;
  logic [NodeW-1:0]      rq_q, rq_d;
  logic [TotW-1:0]       tot_q, tot_d;
  logic [WeightBits-1:0] key_q [MaxNodes];
  logic [WeightBits-1:0] key_d [MaxNodes];
  logic [NodeW-1:0]      par_q [MaxNodes];
  logic [NodeW-1:0]      par_d [MaxNodes];
  logic [NodeW-1:0]      o_node_q, o_node_d, o_par_q, o_par_d;
  logic [WeightBits-1:0] o_key_q, o_key_d;
  logic [TotW-1:0]       o_tot_q, o_tot_d;
  logic                  o_got_q, o_got_d, o_last_q, o_last_d;

  // matrix RAM port
  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr, ram_raddr;
  logic [WeightBits:0]   ram_wdata, ram_rdata;
  logic                  ram_pres;
  logic [WeightBits-1:0] ram_w;

  // input fields
  logic [NodeW-1:0]      in_a, in_b;
  logic [WeightBits-1:0] in_w;
  logic                  in_ok;
  logic [CntW-1:0]       n_use;

  // shared comparator and derived decisions
  logic [NodeW-1:0]      kidx;
  logic [WeightBits-1:0] key_rd;
  logic [WeightBits-1:0] cmp_a, cmp_b;
  logic                  cmp_lt;
  logic                  scan_take, relax_upd, add_upd, idx_last;
  logic                  emit_got;
  logic [TotW-1:0]       emit_sum;

  mstp_ram #(
    .Width (WeightBits + 1),
    .Depth (Depth)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_pres = ram_rdata[WeightBits];
  assign ram_w    = ram_rdata[WeightBits-1:0];

  assign in_a  = s_axis_tdata[NodeW-1:0];
  assign in_b  = s_axis_tdata[2*NodeW-1:NodeW];
  assign in_w  = s_axis_tdata[2*NodeW+WeightBits-1:2*NodeW];
  assign in_ok = (in_a != in_b) && (CntW'(in_a) < MaxN) && (CntW'(in_b) < MaxN);

  // node count saturated into 2..MaxNodes
  assign n_use = (cnt_q < MinN) ? MinN : ((cnt_q > MaxN) ? MaxN : cnt_q);

  // key table read: relax pipeline index or the scan/emit counter
  assign kidx   = (state_q == S_RELAX || state_q == S_DRAIN) ? rq_q : idx_q;
  assign key_rd = key_q[kidx];

  // operand selection for the one signed comparator
  always_comb begin
    case (state_q)
      S_SCAN: begin
        cmp_a = key_rd;
        cmp_b = bkey_q;
      end
      S_ADD_CMP: begin
        cmp_a = w_q;
        cmp_b = ram_w;
      end
      default: begin
        cmp_a = ram_w;
        cmp_b = key_rd;
      end
    endcase
  end

  assign cmp_lt    = $signed(cmp_a) < $signed(cmp_b);
  assign scan_take = !vis_q[idx_q] && fin_q[idx_q] && (!bfound_q || cmp_lt);
  assign relax_upd = !vis_q[rq_q] && ram_pres && (!fin_q[rq_q] || cmp_lt);
  assign add_upd   = !ram_pres || cmp_lt;
  assign idx_last  = (idx_q == nlast_q);

  // running tree total for the emit phase
  assign emit_got = fin_q[idx_q];
  assign emit_sum = emit_got ? tot_q + {{NodeW{key_rd[WeightBits-1]}}, key_rd} : tot_q;

  // sequencer next state
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    idx_d    = idx_q;
    bfound_d = bfound_q;
    rv_d     = 1'b0;
    ovalid_d = ovalid_q && !m_axis_tready;
    fin_d    = fin_q;
    vis_d    = vis_q;
    a_d      = a_q;
    b_d      = b_q;
    w_d      = w_q;
    nlast_d  = nlast_q;
    best_d   = best_q;
    bkey_d   = bkey_q;
    rq_d     = idx_q;
    tot_d    = tot_q;
    key_d    = key_q;
    par_d    = par_q;
    o_node_d = o_node_q;
    o_par_d  = o_par_q;
    o_key_d  = o_key_q;
    o_tot_d  = o_tot_q;
    o_got_d  = o_got_q;
    o_last_d = o_last_q;

    ram_we    = 1'b0;
    ram_waddr = {a_q, b_q};
    ram_wdata = {1'b1, w_q};
    ram_raddr = {best_q, idx_q};

    if (cfg_valid_i) begin
      cnt_d = cfg_data_i;
    end

    // relax data returns in the cycle after its row read
    if (rv_q && relax_upd) begin
      fin_d[rq_q] = 1'b1;
      key_d[rq_q] = ram_w;
      par_d[rq_q] = best_q;
    end

    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        ram_raddr = {in_a, in_b};
        if (s_axis_tvalid) begin
          unique case (opcode_e'(s_axis_tuser))
            OP_ADD: begin
              a_d = in_a;
              b_d = in_b;
              w_d = in_w;
              if (in_ok) begin
                state_d = S_ADD_CMP;
              end
            end
            OP_RUN: begin
              fin_d    = '0;
              fin_d[0] = 1'b1;
              vis_d    = '0;
              for (int i = 0; i < MaxNodes; i++) begin
                key_d[i] = '0;
                par_d[i] = '0;
              end
              nlast_d  = NodeW'(n_use - CntW'(1));
              idx_d    = '0;
              bfound_d = 1'b0;
              state_d  = S_SCAN;
            end
            OP_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLR;
            end
            default: ;
          endcase
        end
      end

      S_ADD_CMP: begin
        if (add_upd) begin
          ram_we  = 1'b1;
          state_d = S_ADD_WR2;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_ADD_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = {b_q, a_q};
        state_d   = S_IDLE;
      end

      // least finite key among unvisited nodes, ties to the lower index
      S_SCAN: begin
        if (scan_take) begin
          bfound_d = 1'b1;
          best_d   = idx_q;
          bkey_d   = key_rd;
        end
        if (idx_last) begin
          idx_d = '0;
          if (bfound_q || scan_take) begin
            vis_d[scan_take ? idx_q : best_q] = 1'b1;
            state_d = S_RELAX;
          end else begin
            idx_d   = NodeW'(1);
            tot_d   = '0;
            state_d = S_EMIT;
          end
        end else begin
          idx_d = idx_q + NodeW'(1);
        end
      end

      // stream the chosen node's matrix row through the read port
      S_RELAX: begin
        rv_d = 1'b1;
        rq_d = idx_q;
        if (idx_last) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + NodeW'(1);
        end
      end

      S_DRAIN: begin
        idx_d    = '0;
        bfound_d = 1'b0;
        state_d  = S_SCAN;
      end

      // one result word per node 1..n-1
      S_EMIT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          o_node_d = idx_q;
          o_got_d  = emit_got;
          o_par_d  = emit_got ? par_q[idx_q] : '0;
          o_key_d  = emit_got ? key_rd : '0;
          o_last_d = idx_last;
          o_tot_d  = idx_last ? emit_sum : '0;
          tot_d    = emit_sum;
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + NodeW'(1);
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cnt_q    <= MaxN;
      clr_q    <= '0;
      idx_q    <= '0;
      bfound_q <= 1'b0;
      rv_q     <= 1'b0;
      ovalid_q <= 1'b0;
      fin_q    <= '0;
      vis_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      clr_q    <= clr_d;
      idx_q    <= idx_d;
      bfound_q <= bfound_d;
      rv_q     <= rv_d;
      ovalid_q <= ovalid_d;
      fin_q    <= fin_d;
      vis_q    <= vis_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    w_q      <= w_d;
    nlast_q  <= nlast_d;
    best_q   <= best_d;
    bkey_q   <= bkey_d;
    rq_q     <= rq_d;
    tot_q    <= tot_d;
    key_q    <= key_d;
    par_q    <= par_d;
    o_node_q <= o_node_d;
    o_par_q  <= o_par_d;
    o_key_q  <= o_key_d;
    o_tot_q  <= o_tot_d;
    o_got_q  <= o_got_d;
    o_last_q <= o_last_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OutW'({o_tot_q, o_key_q, o_par_q, o_node_q});
  assign m_axis_tuser  = o_got_q;
  assign m_axis_tlast  = o_last_q;

`ifndef SYNTHESIS
  a_relax_best_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RELAX) |-> vis_q[best_q])
    else $error("relaxing from a node that is not in the tree");

  a_root_finite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> fin_q[0])
    else $error("root key lost during a run");

  a_visit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ($countones(vis_q) <= int'(nlast_q) + 1))
    else $error("more nodes visited than in use");

  a_unreached_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !o_got_q) |-> (o_key_q == '0 && o_par_q == '0))
    else $error("unreached node reports a key or parent");

  a_total_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !o_last_q) |-> (o_tot_q == '0))
    else $error("total reported before the last word");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
// testbench: self-checking bench for minimum_spanning_tree_prim_unit
// drives edge, run and clear words, predicts the tree result words and compares them
// depends on mstp_pkg and the unit's rtl
`default_nettype none

module testbench;
  import mstp_pkg::*;

  localparam int NODES = MAX_NODES;
  // opcode value with no command behind it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // node counts per phase: extremes, saturating values and a few in between
  localparam logic [5:0] COUNT_PLAN [8] = '{6'd2, 6'd63, 6'd0, 6'd5, 6'd1, 6'd33, 6'd12, 6'd32};
  // count whose phase gets the long receiver hold-off
  localparam logic [5:0] SQUEEZE_COUNT = 6'd5;
  localparam int PHASE_WORDS = 11;
  // covers the full matrix sweep of a clear word
  localparam int IDLE_PAUSE = 1100;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_LIMIT = 200000;

  typedef struct packed {
    logic [4:0]  node;
    logic [4:0]  parent;
    logic        reached;
    logic [15:0] key;
    logic [20:0] total;
    logic        last;
  } tree_word_t;

  // edge store, node count and queue of predicted tree words
  class tree_book;
    bit linked [NODES][NODES];
    int link_w [NODES][NODES];
    logic [5:0] node_count;
    tree_word_t expected_words [$];
    int errors;

    function new();
      clear_links();
      node_count = 6'd32;
      errors = 0;
    endfunction

    function void clear_links();
      foreach (linked[i, j]) begin
        linked[i][j] = 1'b0;
        link_w[i][j] = 0;
      end
    endfunction

    function void set_node_count(logic [5:0] value);
      node_count = value;
    endfunction

    // count saturated into the usable range
    function int used_nodes();
      if (node_count < 2) return 2;
      if (node_count > NODES) return NODES;
      return int'(node_count);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // grow the tree from node 0 and queue one word per node 1..n-1
    function void grow_and_report();
      bit has_key [NODES];
      int key [NODES];
      int parent [NODES];
      bit in_tree [NODES];
      int n;
      int best;
      int total;
      tree_word_t w;
      n = used_nodes();
      foreach (has_key[i]) begin
        has_key[i] = 1'b0;
        key[i] = 0;
        parent[i] = 0;
        in_tree[i] = 1'b0;
      end
      has_key[0] = 1'b1;
      total = 0;
      for (int step = 0; step < n; step++) begin
        // least finite key wins, ties to the lower index
        best = -1;
        for (int i = 0; i < n; i++)
          if (!in_tree[i] && has_key[i] && (best < 0 || key[i] < key[best])) best = i;
        if (best < 0) break;
        in_tree[best] = 1'b1;
        // relax neighbors only on a strictly smaller weight
        for (int q = 0; q < n; q++)
          if (!in_tree[q] && linked[best][q] && (!has_key[q] || link_w[best][q] < key[q])) begin
            has_key[q] = 1'b1;
            key[q] = link_w[best][q];
            parent[q] = best;
          end
      end
      for (int i = 1; i < n; i++) begin
        w.node = 5'(i);
        w.reached = has_key[i];
        w.parent = has_key[i] ? 5'(parent[i]) : 5'd0;
        w.key = has_key[i] ? 16'(key[i]) : 16'd0;
        w.last = (i == n - 1);
        if (has_key[i]) total += key[i];
        w.total = w.last ? 21'(total) : 21'd0;
        expected_words = {expected_words, w};
      end
    endfunction

    // an accepted command word
    function void note_command(logic [1:0] op, logic [4:0] a, logic [4:0] b, logic [15:0] w);
      int wv;
      wv = int'($signed(w));
      case (op)
        OP_ADD: begin
          // self loops dropped, parallel edges keep the smaller weight
          if (a != b && (!linked[a][b] || wv < link_w[a][b])) begin
            linked[a][b] = 1'b1;
            linked[b][a] = 1'b1;
            link_w[a][b] = wv;
            link_w[b][a] = wv;
          end
        end
        OP_RUN: grow_and_report();
        OP_CLEAR: clear_links();
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [31:0] expv, logic [31:0] gotv);
      if (expv !== gotv) begin
        $error("%s mismatch: expected %0h, got %0h", name, expv, gotv);
        errors++;
      end
    endfunction

    // an accepted result word against the oldest prediction
    function void check_word(tree_word_t got);
      tree_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word for node %0d with nothing expected", got.node);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      check_field("node_index", 32'(want.node), 32'(got.node));
      check_field("parent_index", 32'(want.parent), 32'(got.parent));
      check_field("reached", 32'(want.reached), 32'(got.reached));
      check_field("node_key", 32'(want.key), 32'(got.key));
      check_field("total_weight", 32'(want.total), 32'(got.total));
      check_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [5:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata;   // end_a, end_b, edge_weight
  logic [1:0] s_axis_tuser;    // opcode
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [47:0] m_axis_tdata;   // node_index, parent_index, node_key, total_weight
  logic [0:0] m_axis_tuser;    // reached
  logic m_axis_tlast;

  tree_book book;
  bit hold_off_requested = 1'b0;
  int calm_left = 0;

  minimum_spanning_tree_prim_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  // gap before a command word: mostly short, a few long, with calm stretches
  function automatic int pick_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_left = $urandom_range(10, 25);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // weights: full range, small values for ties, and the extremes
  function automatic logic [15:0] pick_weight();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 16'($urandom);
    if (roll < 85) return 16'($urandom_range(0, 8) - 4);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  // offer one command word and wait for it to be taken
  task automatic push_command(input logic [1:0] op, input logic [4:0] a, input logic [4:0] b,
                              input logic [15:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, w, b, a};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_command(op, a, b, w);
  endtask

  task automatic push_run();
    push_command(OP_RUN, 5'($urandom), 5'($urandom), 16'($urandom));
  endtask

  task automatic write_node_count(input logic [5:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    book.set_node_count(value);
  endtask

  // stop offering, wait out the predicted words, then let the engine settle
  task automatic drain(input int quiet);
    int guard;
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (book.pending() > 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (quiet) @(posedge clk_i);
  endtask

  // edge batches closed by a run, chains that reach every node, clears and noise
  task automatic random_phase(input int quota);
    int sent;
    int n;
    int k;
    int mode;
    logic [4:0] a;
    logic [4:0] b;
    n = book.used_nodes();
    sent = 0;
    while (sent < quota) begin
      mode = $urandom_range(0, 99);
      if (n > 8 && sent == 0 && mode < 50) begin
        for (int i = 1; i < n; i++)
          push_command(OP_ADD, 5'(i), 5'($urandom_range(0, i - 1)), pick_weight());
        push_run();
        sent += n;
      end else if (mode < 8) begin
        push_command(OP_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom));
        sent++;
      end else if (mode < 14) begin
        push_command(OP_UNUSED, 5'($urandom), 5'($urandom), 16'($urandom));
      end else begin
        k = $urandom_range(1, 8);
        repeat (k) begin
          if ($urandom_range(0, 3) == 0) begin
            a = 5'($urandom);
            b = 5'($urandom);
          end else begin
            a = 5'($urandom_range(0, n - 1));
            b = 5'($urandom_range(0, n - 1));
          end
          push_command(OP_ADD, a, b, pick_weight());
        end
        push_run();
        sent += k + 1;
      end
    end
    push_run();
  endtask

  // receiver: random ready pattern plus one requested long hold-off
  initial begin : receiver
    int roll;
    int len;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_requested) begin
        hold_off_requested = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          m_axis_tready <= 1'b1;
          len = $urandom_range(1, 12);
        end else if (roll < 85) begin
          m_axis_tready <= 1'b0;
          len = $urandom_range(1, 3);
        end else if (roll < 95) begin
          m_axis_tready <= 1'b1;
          len = $urandom_range(40, 120);
        end else begin
          m_axis_tready <= 1'b0;
          len = $urandom_range(10, 50);
        end
        repeat (len - 1) @(posedge clk_i);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      book.check_word({m_axis_tdata[4:0], m_axis_tdata[9:5], m_axis_tuser[0],
                       m_axis_tdata[25:10], m_axis_tdata[46:26], m_axis_tlast});
  end

  // main sequence
  initial begin : stimulus
    book = new();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 6'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 32'd0;
    s_axis_tuser = OP_ADD;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty graph: every node unreached
    push_run();
    // parallel edge, larger weight second is dropped
    push_command(OP_ADD, 5'd0, 5'd31, 16'h8000);
    push_command(OP_ADD, 5'd31, 5'd0, 16'h7fff);
    // self loop is ignored
    push_command(OP_ADD, 5'd5, 5'd5, 16'd100);
    push_command(OP_ADD, 5'd0, 5'd1, 16'h7fff);
    // parallel edge, smaller weight second replaces
    push_command(OP_ADD, 5'd1, 5'd2, 16'hffff);
    push_command(OP_ADD, 5'd2, 5'd1, 16'hfffb);
    // equal keys: the lower index goes first
    push_command(OP_ADD, 5'd0, 5'd4, 16'd3);
    push_command(OP_ADD, 5'd0, 5'd6, 16'd3);
    push_command(OP_ADD, 5'd4, 5'd7, 16'd2);
    push_command(OP_ADD, 5'd6, 5'd7, 16'd2);
    push_command(OP_ADD, 5'd31, 5'd30, 16'h7fff);
    push_command(OP_UNUSED, 5'd31, 5'd31, 16'hffff);
    push_run();
    // clear then an island away from node 0
    push_command(OP_CLEAR, 5'd0, 5'd0, 16'd0);
    push_command(OP_ADD, 5'd30, 5'd29, 16'd0);
    push_run();
    push_command(OP_ADD, 5'd0, 5'd29, 16'h8000);
    push_run();

    foreach (COUNT_PLAN[p]) begin
      drain(IDLE_PAUSE);
      write_node_count(COUNT_PLAN[p]);
      if (COUNT_PLAN[p] == SQUEEZE_COUNT) hold_off_requested = 1'b1;
      random_phase(PHASE_WORDS);
    end

    drain(IDLE_PAUSE);
    if (book.pending() != 0) begin
      $error("%0d result words never arrived", book.pending());
      book.errors++;
    end
    if (book.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
